// File: sv/eops_pkg.sv
// ----------------------------------------------------------------------------
// eops_pkg
// shared types and constants for the ellipse orbit point stepper
// ----------------------------------------------------------------------------
`default_nettype none
package eops_pkg;

  localparam int CordicSteps = 24;
  localparam int CordicW     = 34;
  localparam int ZW          = 34;
  localparam int SqW         = 64;

  localparam logic [CordicW-1:0] CORDIC_X0 = 34'd652032874;

  localparam logic [2:0] CFG_AXIS_X = 3'd0;
  localparam logic [2:0] CFG_AXIS_Y = 3'd1;
  localparam logic [2:0] CFG_STEP   = 3'd2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CORD  = 4'd1;
  localparam logic [3:0] ST_FOLD  = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_MUL2  = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_DIVX  = 4'd6;
  localparam logic [3:0] ST_DIVY  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;
  localparam logic [3:0] ST_SQ1   = 4'd9;
  localparam logic [3:0] ST_SQ2   = 4'd10;
  localparam logic [3:0] ST_NUMX  = 4'd11;
  localparam logic [3:0] ST_NUMY  = 4'd12;

  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 34'd536870912;
      5'd1:  v = 34'd316933406;
      5'd2:  v = 34'd167458907;
      5'd3:  v = 34'd85004756;
      5'd4:  v = 34'd42667335;
      5'd5:  v = 34'd21354465;
      5'd6:  v = 34'd10679838;
      5'd7:  v = 34'd5340245;
      5'd8:  v = 34'd2670163;
      5'd9:  v = 34'd1335086;
      5'd10: v = 34'd667544;
      5'd11: v = 34'd333772;
      5'd12: v = 34'd166886;
      5'd13: v = 34'd83443;
      5'd14: v = 34'd41721;
      5'd15: v = 34'd20860;
      5'd16: v = 34'd10430;
      5'd17: v = 34'd5215;
      5'd18: v = 34'd2607;
      5'd19: v = 34'd1303;
      5'd20: v = 34'd651;
      5'd21: v = 34'd325;
      5'd22: v = 34'd162;
      5'd23: v = 34'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/eops_stream_if.sv
// ----------------------------------------------------------------------------
// eops_stream_if
// valid/ready channel with a packed payload
// ----------------------------------------------------------------------------
`default_nettype none
interface eops_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/ellipse_orbit_point_stepper_core.sv
// ----------------------------------------------------------------------------
// ellipse_orbit_point_stepper_core
// point on a centred ellipse at the current orbit angle
// ----------------------------------------------------------------------------
// Each input beat optionally advances the orbit angle by angle_step and then
// returns the ellipse point at that angle. From the accepting edge, a beat
// passes the quadrant fold, the CORDIC loop, the squaring multiplies, the
// square root and the two divides (root and divides share one restoring
// unit, each started from its own state), then the output load, before the
// block is ready again. The result sits in an output register, so the next
// beat is taken while it waits; a result still waiting when the next one is
// done holds the block in the output state until the old beat leaves.
`default_nettype none
module ellipse_orbit_point_stepper_core
  import eops_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int AXIS_BITS  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  eops_stream_if.sink      in_s,
  eops_stream_if.source    out_s,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [3:0]            state_r;
  logic [AXIS_BITS-1:0]  ax_r, ay_r;
  logic [15:0]           step_r;
  logic [ANGLE_BITS-1:0] ang_r;
  logic [1:0]            quad_r;
  logic signed [18:0]    cq_r, sq_r;
  logic [31:0]           bc_r, as_r, ab_r;
  logic [63:0]           bc2_r, as2_r, s_r, d_r;
  logic [63:0]           num_r;
  logic                  sgn_r;
  logic signed [10:0]    px_r, py_r;
  logic                  ovalid_r;
  logic [37:0]           odata_r;
  logic                  load_out;

  // fold to nearest quadrant
  logic [31:0] turn, rest;
  logic [1:0]  quad;
  assign turn = 32'(ang_r) << (32 - ANGLE_BITS);
  assign quad = 2'((turn + 32'h2000_0000) >> 30);
  assign rest = turn - {quad, 30'd0};

  logic              c_start, c_done;
  logic signed [18:0] c_cos, c_sin;
  eops_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .turn(rest),
    .done(c_done), .cos_q15(c_cos), .sin_q15(c_sin)
  );

  logic        u_start, u_sqrt, u_done;
  logic [63:0] u_num, u_res;
  eops_sqrtdiv u_unit (
    .clk(clk), .rst_n(rst_n), .start(u_start), .is_sqrt(u_sqrt),
    .num(u_num), .den(d_r[32:0]), .done(u_done), .result(u_res)
  );

  // magnitudes never exceed 2^15 + 1
  logic [15:0] mag_c, mag_s;
  assign mag_c = cq_r[18] ? 16'(-cq_r) : 16'(cq_r);
  assign mag_s = sq_r[18] ? 16'(-sq_r) : 16'(sq_r);

  // saturate a magnitude quotient to an 11-bit signed pixel
  function automatic logic signed [10:0] sat(input logic [63:0] q, input logic neg);
    logic signed [10:0] v;
    if (!neg) v = (q > 64'd1023) ? 11'sd1023 : 11'(q);
    else      v = (q > 64'd1024) ? -11'sd1024 : 11'(-q);
    return v;
  endfunction

  assign in_s.ready  = (state_r == ST_IDLE);
  assign out_s.valid = ovalid_r;
  assign out_s.data  = odata_r;
  // angle is settled once the fold state is reached
  assign c_start = (state_r == ST_FOLD);
  assign u_start = (state_r == ST_SQ2) || (state_r == ST_NUMX) || (state_r == ST_NUMY);
  assign u_sqrt  = (state_r == ST_SQ2);
  assign u_num   = (state_r == ST_SQ2) ? s_r : num_r;
  // output register is free when empty or its beat leaves this cycle
  assign load_out = (state_r == ST_OUT) && (!ovalid_r || out_s.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      ax_r     <= AXIS_BITS'(100);
      ay_r     <= AXIS_BITS'(70);
      step_r   <= '0;
      ang_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AXIS_X[1:0]: ax_r <= cfg_data[AXIS_BITS-1:0];
          CFG_AXIS_Y[1:0]: ay_r <= cfg_data[AXIS_BITS-1:0];
          CFG_STEP[1:0]:   step_r <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) ovalid_r <= 1'b1;
      else if (out_s.valid && out_s.ready) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_s.valid && in_s.ready) begin
            if (in_s.data[0]) ang_r <= ang_r + ANGLE_BITS'({{16{step_r[15]}}, step_r});
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          quad_r  <= quad;
          state_r <= ST_CORD;
        end
        ST_CORD: begin
          if (c_done) begin
            case (quad_r)
              2'd0: begin cq_r <= c_cos;          sq_r <= c_sin; end
              2'd1: begin cq_r <= 19'(-c_sin);    sq_r <= c_cos; end
              2'd2: begin cq_r <= 19'(-c_cos);    sq_r <= 19'(-c_sin); end
              default: begin cq_r <= c_sin;       sq_r <= 19'(-c_cos); end
            endcase
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          bc_r <= 32'(ay_r) * 32'(mag_c);
          as_r <= 32'(ax_r) * 32'(mag_s);
          ab_r <= 32'(ax_r) * 32'(ay_r);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          bc2_r <= 64'(bc_r) * 64'(bc_r);
          as2_r <= 64'(as_r) * 64'(as_r);
          state_r <= ST_SQ1;
        end
        ST_SQ1: begin
          s_r <= bc2_r + as2_r;
          state_r <= ST_SQ2;
        end
        ST_SQ2: state_r <= ST_SQRT;
        ST_SQRT: begin
          if (u_done) begin
            d_r <= u_res;
            num_r <= 64'(ab_r) * 64'(mag_c);
            sgn_r <= cq_r[18];
            state_r <= ST_NUMX;
          end
        end
        ST_NUMX: state_r <= ST_DIVX;
        ST_DIVX: begin
          if (u_done) begin
            px_r <= (d_r == 64'd0) ? 11'sd0 : sat(u_res, sgn_r);
            num_r <= 64'(ab_r) * 64'(mag_s);
            sgn_r <= sq_r[18];
            state_r <= ST_NUMY;
          end
        end
        ST_NUMY: state_r <= ST_DIVY;
        ST_DIVY: begin
          if (u_done) begin
            py_r <= (d_r == 64'd0) ? 11'sd0 : sat(u_res, sgn_r);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            odata_r <= {px_r, py_r, 16'(ang_r)};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/eops_cordic.sv
// ----------------------------------------------------------------------------
// eops_cordic
// one rotation step per cycle, 24 steps, q15 rounded sin/cos
// ----------------------------------------------------------------------------
`default_nettype none
module eops_cordic
  import eops_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] turn,
  output logic             done,
  output logic signed [18:0] cos_q15,
  output logic signed [18:0] sin_q15
);
  logic signed [CordicW-1:0] x_r, y_r;
  logic signed [ZW-1:0]      z_r;
  logic [4:0]                i_r;
  logic                      busy_r;
  logic signed [CordicW-1:0] dx, dy, xr, yr;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign done = busy_r && (i_r == 5'(CordicSteps));
  assign xr = x_r + 34'sd16384;
  assign yr = y_r + 34'sd16384;
  assign cos_q15 = 19'(xr >>> 15);
  assign sin_q15 = 19'(yr >>> 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= {{2{turn[31]}}, turn};
    end else if (busy_r) begin
      if (i_r == 5'(CordicSteps)) begin
        busy_r <= 1'b0;
      end else begin
        i_r <= i_r + 5'd1;
        if (!z_r[ZW-1]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - atan_turn(i_r);
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + atan_turn(i_r);
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/eops_sqrtdiv.sv
// ----------------------------------------------------------------------------
// eops_sqrtdiv
// shared restoring unit: 64-bit integer square root or 64-bit by 33-bit divide
// ----------------------------------------------------------------------------
`default_nettype none
module eops_sqrtdiv
  import eops_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          is_sqrt,
  input  wire logic [63:0]   num,
  input  wire logic [32:0]   den,
  output logic               done,
  output logic [63:0]        result
);
  logic [63:0] q_r, rem_r;
  logic [65:0] acc_r;
  logic [32:0] den_r;
  logic        sq_r, busy_r;
  logic [6:0]  n_r;
  logic [65:0] acc_s, trial;
  logic [63:0] q_s;

  assign done = busy_r && (n_r == 7'd0) && !start;

  always_comb begin
    q_s = sq_r ? {32'd0, result[31:0]} : '0;
    if (sq_r) begin
      acc_s = {acc_r[63:0], rem_r[63:62]};
      trial = {q_s[63:0], 2'b01};
    end else begin
      acc_s = {acc_r[64:0], rem_r[63]};
      trial = {33'd0, den_r};
    end
  end
  assign result = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      sq_r   <= is_sqrt;
      n_r    <= is_sqrt ? 7'd32 : 7'd64;
      rem_r  <= num;
      den_r  <= den;
      acc_r  <= '0;
      q_r    <= '0;
    end else if (busy_r && n_r != 7'd0) begin
      n_r   <= n_r - 7'd1;
      rem_r <= sq_r ? {rem_r[61:0], 2'b00} : {rem_r[62:0], 1'b0};
      if (acc_s >= trial) begin
        acc_r <= acc_s - trial;
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        acc_r <= acc_s;
        q_r   <= {q_r[62:0], 1'b0};
      end
    end else if (busy_r) begin
      busy_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: sv/eops_checker.sv
// ----------------------------------------------------------------------------
// eops_checker
// port-level checks bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module eops_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [37:0] out_data
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("reset");
endmodule

bind ellipse_orbit_point_stepper_core eops_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data)
);
`default_nettype wire
